/* src/oads_pkg.sv */
// Shared types and constants for the obstacle avoidance drive sequencer.
// No dependencies; the sequencer module imports this package.
package oads_pkg;

  localparam int OADS_TIME_BITS = 32;
  localparam int OADS_CFG_IDX_BITS = 3;
  localparam int OADS_CFG_DATA_BITS = 16;

  localparam logic [9:0] NO_ECHO_CM = 10'd999;

  typedef enum logic [1:0] {
    MOT_STOP = 2'd0,
    MOT_FWD  = 2'd1,
    MOT_TURN = 2'd2
  } motion_t;

  typedef enum logic [OADS_CFG_IDX_BITS-1:0] {
    REG_OBSTACLE_CM    = 3'd0,
    REG_TURN_MS        = 3'd1,
    REG_SETTLE_MS      = 3'd2,
    REG_CHECK_MS       = 3'd3,
    REG_COOLDOWN_MS    = 3'd4,
    REG_START_KEY_CODE = 3'd5,
    REG_SERVO_KEY_CODE = 3'd6,
    REG_DRIVE_SPEED    = 3'd7
  } cfg_reg_t;

  localparam logic [9:0] RST_OBSTACLE_CM    = 10'd40;
  localparam logic [15:0] RST_TURN_MS       = 16'd350;
  localparam logic [15:0] RST_SETTLE_MS     = 16'd300;
  localparam logic [15:0] RST_CHECK_MS      = 16'd100;
  localparam logic [15:0] RST_COOLDOWN_MS   = 16'd250;
  localparam logic [7:0] RST_START_KEY_CODE = 8'd64;
  localparam logic [7:0] RST_SERVO_KEY_CODE = 8'd22;
  localparam logic [7:0] RST_DRIVE_SPEED    = 8'd50;

endpackage

/* src/oads_if.sv */
// Valid/ready channel interfaces for the tick input and the drive result.
// Depends on nothing beyond the handshake convention shared by both sides.
interface oads_in_if;
  logic       valid;
  logic       ready;
  logic       key_valid;
  logic [7:0] key_code;
  logic [9:0] range_cm;

  modport source (output valid, key_valid, key_code, range_cm, input ready);
  modport sink (input valid, key_valid, key_code, range_cm, output ready);
endinterface

interface oads_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] motion;
  logic       motion_changed;
  logic [7:0] speed;
  logic       run_flag;
  logic       servo_open_flag;
  logic       sampled;
  logic       obstacle;

  modport source (output valid, motion, motion_changed, speed, run_flag,
                  servo_open_flag, sampled, obstacle, input ready);
  modport sink (input valid, motion, motion_changed, speed, run_flag,
                servo_open_flag, sampled, obstacle, output ready);
endinterface

/* src/obstacle_avoid_drive_sequencer.sv */
// Obstacle avoidance drive sequencer, one millisecond tick per transfer.
// The input transfer is captured in an input register and the result in a result register.
// Throughput: one tick per cycle unless the output stalls; the tick state update is a single pass of compares and adds.
// Reset (rst_n low, synchronous) clears time, motion and flags and loads register defaults.
// Depends on oads_pkg and the channel interfaces in oads_if.sv.
module obstacle_avoid_drive_sequencer
  import oads_pkg::*;
#(
  parameter int TIME_BITS = OADS_TIME_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  oads_in_if.sink                       in_if,
  oads_out_if.source                    out_if,
  input  logic                          cfg_we,
  input  logic [OADS_CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [OADS_CFG_DATA_BITS-1:0] cfg_data
);

  typedef logic [TIME_BITS-1:0] tick_t;

  logic [9:0]  obstacle_cm_r;
  logic [15:0] turn_ms_r, settle_ms_r, check_ms_r, cooldown_ms_r;
  logic [7:0]  start_key_r, servo_key_r, drive_speed_r;

  logic       s1_valid_r;
  logic       s1_kv_r;
  logic [7:0] s1_kc_r;
  logic [9:0] s1_range_r;

  tick_t   now_r, turn_end_r, settle_end_r, last_check_r, last_key_r;
  tick_t   turn_end_nxt, settle_end_nxt, last_check_nxt, last_key_nxt;
  motion_t motion_r, motion_nxt;
  logic    running_r, running_nxt;
  logic    servo_open_r, servo_open_nxt;
  logic    sampled_nxt, obstacle_nxt;

  logic       out_valid_r;
  motion_t    out_motion_r;
  logic       out_changed_r;
  logic [7:0] out_speed_r;
  logic       out_run_r, out_servo_r, out_sampled_r, out_obstacle_r;

  logic advance;

  assign advance     = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obstacle_cm_r <= RST_OBSTACLE_CM;
      turn_ms_r     <= RST_TURN_MS;
      settle_ms_r   <= RST_SETTLE_MS;
      check_ms_r    <= RST_CHECK_MS;
      cooldown_ms_r <= RST_COOLDOWN_MS;
      start_key_r   <= RST_START_KEY_CODE;
      servo_key_r   <= RST_SERVO_KEY_CODE;
      drive_speed_r <= RST_DRIVE_SPEED;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_OBSTACLE_CM:    obstacle_cm_r <= cfg_data[9:0];
        REG_TURN_MS:        turn_ms_r     <= cfg_data;
        REG_SETTLE_MS:      settle_ms_r   <= cfg_data;
        REG_CHECK_MS:       check_ms_r    <= cfg_data;
        REG_COOLDOWN_MS:    cooldown_ms_r <= cfg_data;
        REG_START_KEY_CODE: start_key_r   <= cfg_data[7:0];
        REG_SERVO_KEY_CODE: servo_key_r   <= cfg_data[7:0];
        REG_DRIVE_SPEED:    drive_speed_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      s1_kv_r    <= in_if.key_valid;
      s1_kc_r    <= in_if.key_code;
      s1_range_r <= in_if.range_cm;
    end
  end

  always_comb begin
    tick_t now;
    tick_t turn_gap;
    tick_t settle_gap;
    logic  key_ok;
    logic  turn_done;
    logic  settled;
    logic  check_due;
    now            = now_r;
    motion_nxt     = motion_r;
    running_nxt    = running_r;
    servo_open_nxt = servo_open_r;
    turn_end_nxt   = turn_end_r;
    settle_end_nxt = settle_end_r;
    last_check_nxt = last_check_r;
    last_key_nxt   = last_key_r;
    sampled_nxt    = 1'b0;
    obstacle_nxt   = 1'b0;

    key_ok = s1_kv_r && (tick_t'(now - last_key_r) >= TIME_BITS'(cooldown_ms_r));
    if (key_ok) begin
      last_key_nxt = now;
      if (s1_kc_r == start_key_r) begin
        running_nxt = !running_r;
        if (running_r) begin
          motion_nxt = MOT_STOP;
        end
      end else if (s1_kc_r == servo_key_r) begin
        servo_open_nxt = !servo_open_r;
      end
    end

    turn_gap  = tick_t'(now - turn_end_r);
    turn_done = !turn_gap[TIME_BITS-1];
    if (motion_nxt == MOT_TURN && turn_done) begin
      motion_nxt     = MOT_STOP;
      settle_end_nxt = tick_t'(now + TIME_BITS'(settle_ms_r));
    end

    settle_gap = tick_t'(now - settle_end_nxt);
    settled    = !settle_gap[TIME_BITS-1];
    check_due  = tick_t'(now - last_check_r) >= TIME_BITS'(check_ms_r);
    if (!running_nxt) begin
      motion_nxt = MOT_STOP;
    end else if (motion_nxt != MOT_TURN && settled && check_due) begin
      last_check_nxt = now;
      sampled_nxt    = 1'b1;
      obstacle_nxt   = (s1_range_r != NO_ECHO_CM) && (s1_range_r <= obstacle_cm_r);
      if (obstacle_nxt) begin
        motion_nxt   = MOT_TURN;
        turn_end_nxt = tick_t'(now + TIME_BITS'(turn_ms_r));
      end else begin
        motion_nxt = MOT_FWD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r        <= '0;
      turn_end_r   <= '0;
      settle_end_r <= '0;
      last_check_r <= '0;
      last_key_r   <= '0;
      motion_r     <= MOT_STOP;
      running_r    <= 1'b0;
      servo_open_r <= 1'b0;
    end else if (advance) begin
      now_r        <= tick_t'(now_r + 1'b1);
      turn_end_r   <= turn_end_nxt;
      settle_end_r <= settle_end_nxt;
      last_check_r <= last_check_nxt;
      last_key_r   <= last_key_nxt;
      motion_r     <= motion_nxt;
      running_r    <= running_nxt;
      servo_open_r <= servo_open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_motion_r   <= motion_nxt;
      out_changed_r  <= (motion_nxt != motion_r);
      out_speed_r    <= (motion_nxt == MOT_STOP) ? 8'd0 : drive_speed_r;
      out_run_r      <= running_nxt;
      out_servo_r    <= servo_open_nxt;
      out_sampled_r  <= sampled_nxt;
      out_obstacle_r <= obstacle_nxt;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.motion          = out_motion_r;
  assign out_if.motion_changed  = out_changed_r;
  assign out_if.speed           = out_speed_r;
  assign out_if.run_flag        = out_run_r;
  assign out_if.servo_open_flag = out_servo_r;
  assign out_if.sampled         = out_sampled_r;
  assign out_if.obstacle        = out_obstacle_r;

endmodule
